### sv/rfd_pkg.sv
// Shared types and constants for the response frame decoder.
`default_nettype none

package rfd_pkg;

  // Message opcodes
  localparam logic [15:0] OP_FOLLOW   = 16'd4;
  localparam logic [15:0] OP_USERLIST = 16'd7;
  localparam logic [15:0] OP_STAT     = 16'd8;
  localparam logic [15:0] OP_NOTIF    = 16'd9;
  localparam logic [15:0] OP_ACK      = 16'd10;
  localparam logic [15:0] OP_ERROR    = 16'd11;

  // Default depth of the result queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    MSG_NOTIF = 2'd0,
    MSG_ACK   = 2'd1,
    MSG_ERROR = 2'd2,
    MSG_BAD   = 2'd3
  } msg_kind_t;

  typedef enum logic [3:0] {
    FLD_NOTIF_TYPE = 4'd0,
    FLD_TEXT       = 4'd1,
    FLD_STR_END    = 4'd2,
    FLD_ACKED_OP   = 4'd3,
    FLD_USERS      = 4'd4,
    FLD_POSTS      = 4'd5,
    FLD_FOLLOWERS  = 4'd6,
    FLD_FOLLOWING  = 4'd7,
    FLD_ERR_OP     = 4'd8,
    FLD_BAD_OP     = 4'd9
  } field_kind_t;

  typedef struct packed {
    msg_kind_t          msg_kind;
    field_kind_t        field_kind;
    logic signed [15:0] field_value;
    logic               last;
  } result_t;

endpackage

`default_nettype wire

### sv/rfd_if.sv
// Valid/ready channel interfaces for received bytes and decoded results.
`default_nettype none

interface rfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfd_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         msg_kind;
  logic [3:0]         field_kind;
  logic signed [15:0] field_value;
  logic               last;

  modport source (output valid, output msg_kind, output field_kind, output field_value,
                  output last, input ready);
  modport sink   (input valid, input msg_kind, input field_kind, input field_value,
                  input last, output ready);
endinterface

`default_nettype wire

### sv/rfd_front.sv
// Front end: takes received bytes, tracks the frame position and builds result records.
`default_nettype none

module rfd_front (
  input  logic              clk,
  input  logic              rst,
  rfd_byte_if.sink          rx,
  input  logic              q_full,
  output logic              push,
  output rfd_pkg::result_t  res
);
  import rfd_pkg::*;

  logic [3:0]  pos, pos_next;
  logic [15:0] frame_op, frame_op_next;
  logic [15:0] acked_op, acked_op_next;
  logic [7:0]  hold, hold_next;
  logic [14:0] term_cnt, term_cnt_next;

  logic        accept;
  logic        emit;
  logic [7:0]  b;
  logic [15:0] joined;
  logic        frame_known;
  logic        acked_list;
  logic        acked_ext;

  function automatic result_t mk_res(msg_kind_t mk, field_kind_t fk, logic [15:0] v,
                                     logic l);
    result_t r;
    r.msg_kind    = mk;
    r.field_kind  = fk;
    r.field_value = signed'(v);
    r.last        = l;
    return r;
  endfunction

  // A byte is taken whenever the queue has room for a possible result
  assign rx.ready = !q_full;
  assign accept   = rx.valid && !q_full;
  assign push     = accept && emit;

  assign b           = rx.rx_byte;
  assign joined      = {hold, b};
  assign frame_known = (joined == OP_NOTIF) || (joined == OP_ACK) || (joined == OP_ERROR);
  assign acked_list  = (acked_op == OP_FOLLOW) || (acked_op == OP_USERLIST);
  assign acked_ext   = (joined == OP_FOLLOW) || (joined == OP_USERLIST) ||
                       (joined == OP_STAT);

  // Per-byte frame decode
  always_comb begin
    pos_next      = pos;
    frame_op_next = frame_op;
    acked_op_next = acked_op;
    hold_next     = hold;
    term_cnt_next = term_cnt;
    emit          = 1'b0;
    res           = mk_res(MSG_NOTIF, FLD_NOTIF_TYPE, 16'd0, 1'b0);

    if (pos == 4'd0) begin
      hold_next = b;
      pos_next  = 4'd1;
    end else if (pos == 4'd1) begin
      frame_op_next = joined;
      term_cnt_next = '0;
      if (!frame_known) begin
        pos_next = 4'd0;
        emit     = 1'b1;
        res      = mk_res(MSG_BAD, FLD_BAD_OP, joined, 1'b1);
      end else begin
        pos_next = 4'd2;
      end
    end else if (frame_op == OP_NOTIF) begin
      // Notification: type byte, then two zero-terminated strings
      if (pos == 4'd2) begin
        pos_next      = 4'd3;
        term_cnt_next = '0;
        emit          = 1'b1;
        res           = mk_res(MSG_NOTIF, FLD_NOTIF_TYPE, {15'd0, b != 8'd0}, 1'b0);
      end else if (pos != 4'd3) begin
        pos_next      = 4'd0;
        term_cnt_next = '0;
      end else if (b != 8'd0) begin
        emit = 1'b1;
        res  = mk_res(MSG_NOTIF, FLD_TEXT, {8'd0, b}, 1'b0);
      end else if (term_cnt != '0) begin
        pos_next      = 4'd0;
        term_cnt_next = '0;
        emit          = 1'b1;
        res           = mk_res(MSG_NOTIF, FLD_STR_END, 16'd0, 1'b1);
      end else begin
        term_cnt_next = term_cnt + 15'd1;
        emit          = 1'b1;
        res           = mk_res(MSG_NOTIF, FLD_STR_END, 16'd0, 1'b0);
      end
    end else if (frame_op == OP_ERROR) begin
      // Error: one 16-bit opcode
      if (pos == 4'd2) begin
        hold_next = b;
        pos_next  = 4'd3;
      end else if (pos == 4'd3) begin
        acked_op_next = joined;
        pos_next      = 4'd0;
        term_cnt_next = '0;
        emit          = 1'b1;
        res           = mk_res(MSG_ERROR, FLD_ERR_OP, joined, 1'b1);
      end else begin
        pos_next      = 4'd0;
        term_cnt_next = '0;
      end
    end else if (pos == 4'd2) begin
      hold_next = b;
      pos_next  = 4'd3;
    end else if (pos == 4'd3) begin
      // Ack: acked opcode decides whether more follows
      acked_op_next = joined;
      emit          = 1'b1;
      if (acked_ext) begin
        pos_next = 4'd4;
        res      = mk_res(MSG_ACK, FLD_ACKED_OP, joined, 1'b0);
      end else begin
        pos_next      = 4'd0;
        term_cnt_next = '0;
        res           = mk_res(MSG_ACK, FLD_ACKED_OP, joined, 1'b1);
      end
    end else if (acked_list) begin
      // Follow / user list: count, then that many names
      if (pos == 4'd4) begin
        hold_next = b;
        pos_next  = 4'd5;
      end else if (pos == 4'd5) begin
        emit = 1'b1;
        if (joined == 16'd0 || joined[15]) begin
          pos_next      = 4'd0;
          term_cnt_next = '0;
          res           = mk_res(MSG_ACK, FLD_USERS, joined, 1'b1);
        end else begin
          term_cnt_next = joined[14:0];
          pos_next      = 4'd6;
          res           = mk_res(MSG_ACK, FLD_USERS, joined, 1'b0);
        end
      end else if (pos != 4'd6) begin
        pos_next      = 4'd0;
        term_cnt_next = '0;
      end else if (b != 8'd0) begin
        emit = 1'b1;
        res  = mk_res(MSG_ACK, FLD_TEXT, {8'd0, b}, 1'b0);
      end else if (term_cnt == 15'd1) begin
        pos_next      = 4'd0;
        term_cnt_next = '0;
        emit          = 1'b1;
        res           = mk_res(MSG_ACK, FLD_STR_END, 16'd0, 1'b1);
      end else begin
        term_cnt_next = term_cnt - 15'd1;
        emit          = 1'b1;
        res           = mk_res(MSG_ACK, FLD_STR_END, 16'd0, 1'b0);
      end
    end else if (acked_op == OP_STAT) begin
      // Stat: three 16-bit counts
      unique case (pos)
        4'd4, 4'd6, 4'd8: begin
          hold_next = b;
          pos_next  = pos + 4'd1;
        end
        4'd5: begin
          pos_next = 4'd6;
          emit     = 1'b1;
          res      = mk_res(MSG_ACK, FLD_POSTS, joined, 1'b0);
        end
        4'd7: begin
          pos_next = 4'd8;
          emit     = 1'b1;
          res      = mk_res(MSG_ACK, FLD_FOLLOWERS, joined, 1'b0);
        end
        4'd9: begin
          pos_next      = 4'd0;
          term_cnt_next = '0;
          emit          = 1'b1;
          res           = mk_res(MSG_ACK, FLD_FOLLOWING, joined, 1'b1);
        end
        default: begin
          pos_next      = 4'd0;
          term_cnt_next = '0;
        end
      endcase
    end else begin
      pos_next      = 4'd0;
      term_cnt_next = '0;
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      frame_op <= '0;
      acked_op <= '0;
      hold     <= '0;
      term_cnt <= '0;
    end else if (accept) begin
      pos      <= pos_next;
      frame_op <= frame_op_next;
      acked_op <= acked_op_next;
      hold     <= hold_next;
      term_cnt <= term_cnt_next;
    end
  end

endmodule

`default_nettype wire

### sv/rfd_queue.sv
// Small result queue between the decode front end and the output stage.
`default_nettype none

module rfd_queue #(
  parameter int DEPTH = rfd_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rfd_pkg::result_t  din,
  output logic              full,
  input  logic              pop,
  output rfd_pkg::result_t  dout,
  output logic              nempty
);
  import rfd_pkg::*;

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  result_t         slots [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full   = (count == FullCnt);
  assign nempty = (count != '0);
  assign dout   = slots[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastIdx) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastIdx) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### sv/rfd_back.sv
// Back end: output register that presents results to the consumer.
`default_nettype none

module rfd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_nempty,
  input  rfd_pkg::result_t  q_data,
  output logic              pop,
  rfd_result_if.source      rsp
);
  import rfd_pkg::*;

  logic    valid;
  result_t hold_res;

  // Refill whenever the register is empty or its transfer completes
  assign pop = q_nempty && (!valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (pop) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      hold_res <= q_data;
    end
  end

  assign rsp.valid       = valid;
  assign rsp.msg_kind    = hold_res.msg_kind;
  assign rsp.field_kind  = hold_res.field_kind;
  assign rsp.field_value = hold_res.field_value;
  assign rsp.last        = hold_res.last;

endmodule

`default_nettype wire

### sv/response_frame_decoder.sv
// Top level of the response frame decoder: front end, result queue and output stage.
//
//   channel  dir  payload                                      transfer when
//   rx       in   rx_byte[7:0]                                 rx.valid & rx.ready
//   rsp      out  msg_kind[1:0] field_kind[3:0]                rsp.valid & rsp.ready
//                 field_value[15:0] signed, last
//
// One byte per cycle is taken while the result queue has room; the frame state
// updates in the same cycle and any result enters the queue.
// A result passes through the queue, then the output register, on its way to rsp;
// latency grows only while rsp is stalled.
// rx stalls only once the queue (QUEUE_DEPTH entries) is full.
// Synchronous reset returns the decoder to the start of a message and empties the queue.
`default_nettype none

module response_frame_decoder #(
  parameter int QUEUE_DEPTH = rfd_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  rfd_byte_if.sink      rx,
  rfd_result_if.source  rsp
);
  import rfd_pkg::*;

  logic    push, pop, q_full, q_nempty;
  result_t front_res, q_data;

  rfd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .q_full (q_full),
    .push   (push),
    .res    (front_res)
  );

  rfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .din    (front_res),
    .full   (q_full),
    .pop    (pop),
    .dout   (q_data),
    .nempty (q_nempty)
  );

  rfd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_nempty (q_nempty),
    .q_data   (q_data),
    .pop      (pop),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire

### dv/response_frame_decoder_tb.sv
// Self-checking testbench for the response frame decoder: byte stream in, tagged fields out.
`timescale 1ns / 100ps

module response_frame_decoder_tb;
  import rfd_pkg::*;

  localparam int IDLE_LIMIT    = 2000;  // cycles with no transfer before giving up
  localparam int SETTLE_CYCLES = 20;    // quiet time after the last field
  localparam int RANDOM_BYTES  = 1300;

  logic clk = 1'b0;
  logic rst;

  always #5 clk = ~clk;

  rfd_byte_if   byte_ch ();
  rfd_result_if field_ch ();

  response_frame_decoder DUT (
    .clk (clk),
    .rst (rst),
    .rx  (byte_ch),
    .rsp (field_ch)
  );

  // Expected fields, oldest first
  result_t expected_fields[$];

  int field_errors = 0;
  int bytes_sent   = 0;
  int fields_seen  = 0;
  int kind_seen[4] = '{0, 0, 0, 0};
  bit sender_calm  = 1'b0;
  bit receiver_calm = 1'b0;

  // Decoder state as the predictor sees it
  logic [3:0]  frame_pos  = '0;
  logic [15:0] frame_op   = '0;
  logic [15:0] acked_op   = '0;
  logic [7:0]  held_byte  = '0;
  logic [15:0] term_count = '0;

  function automatic result_t make_field(input msg_kind_t mk, input field_kind_t fk,
                                         input logic [15:0] v, input logic l);
    result_t r;
    r.msg_kind    = mk;
    r.field_kind  = fk;
    r.field_value = v;
    r.last        = l;
    return r;
  endfunction

  // Advance the frame state by one byte; returns 1 where a field comes out
  function automatic bit predict_field(input logic [7:0] b, output result_t r);
    logic [15:0] word;
    word = {held_byte, b};
    r = '0;
    if (frame_pos == 4'd0) begin
      held_byte = b;
      frame_pos = 4'd1;
      return 1'b0;
    end
    if (frame_pos == 4'd1) begin
      frame_op = word;
      if (frame_op != OP_NOTIF && frame_op != OP_ACK && frame_op != OP_ERROR) begin
        frame_pos = '0;
        term_count = '0;
        r = make_field(MSG_BAD, FLD_BAD_OP, word, 1'b1);
        return 1'b1;
      end
      frame_pos = 4'd2;
      term_count = '0;
      return 1'b0;
    end

    // Notification: type byte then two zero-terminated strings
    if (frame_op == OP_NOTIF) begin
      if (frame_pos == 4'd2) begin
        frame_pos = 4'd3;
        term_count = '0;
        r = make_field(MSG_NOTIF, FLD_NOTIF_TYPE, (b == 8'h00) ? 16'd0 : 16'd1, 1'b0);
        return 1'b1;
      end
      if (frame_pos != 4'd3) begin
        frame_pos = '0;
        term_count = '0;
        return 1'b0;
      end
      if (b != 8'h00) begin
        r = make_field(MSG_NOTIF, FLD_TEXT, {8'h00, b}, 1'b0);
        return 1'b1;
      end
      term_count = term_count + 16'd1;
      if (term_count >= 16'd2) begin
        frame_pos = '0;
        term_count = '0;
        r = make_field(MSG_NOTIF, FLD_STR_END, 16'd0, 1'b1);
      end else begin
        r = make_field(MSG_NOTIF, FLD_STR_END, 16'd0, 1'b0);
      end
      return 1'b1;
    end

    // Error: one opcode word
    if (frame_op == OP_ERROR) begin
      if (frame_pos == 4'd2) begin
        held_byte = b;
        frame_pos = 4'd3;
        return 1'b0;
      end
      if (frame_pos == 4'd3) begin
        acked_op = word;
        frame_pos = '0;
        term_count = '0;
        r = make_field(MSG_ERROR, FLD_ERR_OP, word, 1'b1);
        return 1'b1;
      end
      frame_pos = '0;
      term_count = '0;
      return 1'b0;
    end

    // Ack: acked opcode, then whatever that opcode carries
    if (frame_pos == 4'd2) begin
      held_byte = b;
      frame_pos = 4'd3;
      return 1'b0;
    end
    if (frame_pos == 4'd3) begin
      acked_op = word;
      if (acked_op == OP_FOLLOW || acked_op == OP_USERLIST || acked_op == OP_STAT) begin
        frame_pos = 4'd4;
        r = make_field(MSG_ACK, FLD_ACKED_OP, word, 1'b0);
      end else begin
        frame_pos = '0;
        term_count = '0;
        r = make_field(MSG_ACK, FLD_ACKED_OP, word, 1'b1);
      end
      return 1'b1;
    end
    if (acked_op == OP_FOLLOW || acked_op == OP_USERLIST) begin
      if (frame_pos == 4'd4) begin
        held_byte = b;
        frame_pos = 4'd5;
        return 1'b0;
      end
      if (frame_pos == 4'd5) begin
        // a count of zero or below ends the list at once
        if (word == 16'd0 || word[15]) begin
          frame_pos = '0;
          term_count = '0;
          r = make_field(MSG_ACK, FLD_USERS, word, 1'b1);
        end else begin
          term_count = word;
          frame_pos = 4'd6;
          r = make_field(MSG_ACK, FLD_USERS, word, 1'b0);
        end
        return 1'b1;
      end
      if (frame_pos != 4'd6) begin
        frame_pos = '0;
        term_count = '0;
        return 1'b0;
      end
      if (b != 8'h00) begin
        r = make_field(MSG_ACK, FLD_TEXT, {8'h00, b}, 1'b0);
        return 1'b1;
      end
      term_count = term_count - 16'd1;
      if (term_count == 16'd0) begin
        frame_pos = '0;
        r = make_field(MSG_ACK, FLD_STR_END, 16'd0, 1'b1);
      end else begin
        r = make_field(MSG_ACK, FLD_STR_END, 16'd0, 1'b0);
      end
      return 1'b1;
    end
    if (acked_op == OP_STAT) begin
      unique case (frame_pos)
        4'd4, 4'd6, 4'd8: begin
          held_byte = b;
          frame_pos = frame_pos + 4'd1;
          return 1'b0;
        end
        4'd5: begin
          frame_pos = 4'd6;
          r = make_field(MSG_ACK, FLD_POSTS, word, 1'b0);
          return 1'b1;
        end
        4'd7: begin
          frame_pos = 4'd8;
          r = make_field(MSG_ACK, FLD_FOLLOWERS, word, 1'b0);
          return 1'b1;
        end
        4'd9: begin
          frame_pos = '0;
          term_count = '0;
          r = make_field(MSG_ACK, FLD_FOLLOWING, word, 1'b1);
          return 1'b1;
        end
        default: ;
      endcase
    end
    frame_pos = '0;
    term_count = '0;
    return 1'b0;
  endfunction

  // Sender gap: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Present one byte and wait for its transfer; valid stays up for a follow-on byte
  task automatic send_byte(input logic [7:0] b);
    int gap;
    result_t f;
    gap = pick_gap();
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
    if (predict_field(b, f)) expected_fields = {expected_fields, f};
  endtask

  task automatic send_word(input logic [15:0] w);
    send_byte(w[15:8]);
    send_byte(w[7:0]);
  endtask

  // Zero-terminated string of non-zero bytes
  task automatic send_text(input int len);
    for (int i = 0; i < len; i++) send_byte(8'($urandom_range(1, 255)));
    send_byte(8'h00);
  endtask

  function automatic int pick_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, 5);
    return $urandom_range(6, 24);
  endfunction

  task automatic send_user_ack(input logic [15:0] op, input logic [15:0] count);
    send_word(OP_ACK);
    send_word(op);
    send_word(count);
    if (count != 16'd0 && !count[15]) begin
      for (int i = 0; i < int'(count); i++) send_text(pick_len());
    end
  endtask

  task automatic send_stat(input logic [15:0] posts, input logic [15:0] followers,
                           input logic [15:0] following);
    send_word(OP_ACK);
    send_word(OP_STAT);
    send_word(posts);
    send_word(followers);
    send_word(following);
  endtask

  // Hold the sender until every expected field is out, then let the block settle
  task automatic drain();
    byte_ch.valid <= 1'b0;
    while (expected_fields.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_bad_opcode();
    send_word(16'hFFFF);
    drain();
  endtask

  task automatic test_notification();
    // public type, two empty strings
    send_word(OP_NOTIF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);
    drain();
  endtask

  task automatic test_error();
    send_word(OP_ERROR);
    send_word(16'h8000);
    drain();
  endtask

  task automatic test_plain_ack();
    send_word(OP_ACK);
    send_word(16'hFFFF);
    drain();
  endtask

  task automatic test_empty_user_list();
    send_user_ack(OP_FOLLOW, 16'd0);
    drain();
  endtask

  task automatic test_stat_ack();
    send_stat(16'h7FFF, 16'h8000, 16'h0000);
    drain();
  endtask

  // Mostly well-formed messages with random content, some noise and cut-off frames
  task automatic test_random_stream();
    int start;
    int r;
    bit paused;
    logic [15:0] op;
    start = bytes_sent;
    paused = 1'b0;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if ($urandom_range(0, 11) == 0) sender_calm = ~sender_calm;
      if (!paused && bytes_sent - start > RANDOM_BYTES / 2) begin
        drain();
        paused = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 25) begin
        send_word(OP_NOTIF);
        send_byte(($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
        send_text(pick_len());
        send_text(pick_len());
      end else if (r < 35) begin
        do op = 16'($urandom_range(0, 65535));
        while (op == OP_FOLLOW || op == OP_USERLIST || op == OP_STAT);
        if ($urandom_range(0, 1) == 0) op = {12'h000, op[3:0]};
        if (op == OP_FOLLOW || op == OP_USERLIST || op == OP_STAT) op = OP_ACK;
        send_word(OP_ACK);
        send_word(op);
      end else if (r < 60) begin
        r = $urandom_range(0, 99);
        op = $urandom_range(0, 1) ? OP_FOLLOW : OP_USERLIST;
        if (r < 15) send_user_ack(op, 16'd0);
        else if (r < 25) send_user_ack(op, {1'b1, 15'($urandom_range(0, 32767))});
        else send_user_ack(op, 16'($urandom_range(1, 4)));
      end else if (r < 75) begin
        send_stat(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)));
      end else if (r < 85) begin
        send_word(OP_ERROR);
        send_word(16'($urandom_range(0, 65535)));
      end else if (r < 92) begin
        do op = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 15))
                                            : 16'($urandom_range(0, 65535));
        while (op == OP_NOTIF || op == OP_ACK || op == OP_ERROR);
        send_word(op);
      end else begin
        // noise: random bytes that may cut into or start a frame
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end
    end
    drain();
  endtask

  task automatic report(input string name, input int exp_val, input int act_val);
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val, act_val);
  endtask

  // Result side: check each transfer against the oldest expectation, then pick ready
  initial begin
    int stall_left;
    int r;
    result_t want;
    stall_left = 0;
    field_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (field_ch.valid && field_ch.ready) begin
        fields_seen++;
        kind_seen[field_ch.msg_kind]++;
        if (expected_fields.size() == 0) begin
          $display("%0t: unexpected field: kind %0d/%0d value %0d last %0b", $time,
                   field_ch.msg_kind, field_ch.field_kind, field_ch.field_value,
                   field_ch.last);
          field_errors++;
        end else begin
          want = expected_fields.pop_front();
          if (field_ch.msg_kind !== want.msg_kind) begin
            report("msg_kind", want.msg_kind, field_ch.msg_kind);
            field_errors++;
          end
          if (field_ch.field_kind !== want.field_kind) begin
            report("field_kind", want.field_kind, field_ch.field_kind);
            field_errors++;
          end
          if (field_ch.field_value !== want.field_value) begin
            report("field_value", want.field_value, field_ch.field_value);
            field_errors++;
          end
          if (field_ch.last !== want.last) begin
            report("last", want.last, field_ch.last);
            field_errors++;
          end
        end
      end
      if ($urandom_range(0, 199) == 0) receiver_calm = ~receiver_calm;
      r = $urandom_range(0, 99);
      if (stall_left > 0) begin
        field_ch.ready <= 1'b0;
        stall_left--;
      end else if (!receiver_calm && r < 25) begin
        field_ch.ready <= 1'b0;
        stall_left = (r < 22) ? $urandom_range(0, 2) : $urandom_range(9, 29);
      end else begin
        field_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if (rst || (byte_ch.valid && byte_ch.ready) || (field_ch.valid && field_ch.ready)) begin
        idle = 0;
      end else begin
        idle++;
        if (idle >= IDLE_LIMIT) begin
          $display("%0t: no transfer for %0d cycles, %0d fields outstanding", $time,
                   idle, expected_fields.size());
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  // Test sequence
  initial begin
    rst             <= 1'b1;
    byte_ch.valid   <= 1'b0;
    byte_ch.rx_byte <= 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_bad_opcode();
    test_notification();
    test_error();
    test_plain_ack();
    test_empty_user_list();
    test_stat_ack();
    test_random_stream();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run: %0d bytes fed, %0d fields checked (notification %0d, ack %0d, error %0d,",
             bytes_sent, fields_seen, kind_seen[MSG_NOTIF], kind_seen[MSG_ACK],
             kind_seen[MSG_ERROR]);
    $display("     bad opcode %0d) with random gaps and stalls on both sides", kind_seen[MSG_BAD]);
    if (field_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### response_frame_decoder.f
sv/rfd_pkg.sv
sv/rfd_if.sv
sv/rfd_front.sv
sv/rfd_queue.sv
sv/rfd_back.sv
sv/response_frame_decoder.sv
dv/response_frame_decoder_tb.sv
